FILE: rtl/key_click_event_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Key click event detector - assertion macros
// Shared property forms for the key click event detector checks.
// ----------------------------------------------------------------------------
`ifndef KEY_CLICK_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define KEY_CLICK_EVENT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, gated off while reset is held.
`define KCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is held.
`define KCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kcd_pkg.sv
// ----------------------------------------------------------------------------
// Key click event detector package
// Phase and event codes, state and configuration records, reset values.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int unsigned StampW = 32;
    localparam int unsigned LimitW = 16;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_LONG     = 3'd3,
        PH_RELEASE  = 3'd4,
        PH_WAIT_DBL = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_DOUBLE_GAP = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_phase              phase;
        logic [StampW-1:0]   press_stamp;
        logic [StampW-1:0]   release_stamp;
        logic [1:0]          clicks;
    } t_kcd_state;

    typedef struct packed {
        logic [LimitW-1:0] debounce_ms;
        logic [LimitW-1:0] long_press_ms;
        logic [LimitW-1:0] double_gap_ms;
    } t_kcd_cfg;

    localparam logic [LimitW-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [LimitW-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [LimitW-1:0] DOUBLE_GAP_RST = 16'd500;

    // Wrapping elapsed time, strictly over the limit.
    function automatic logic elapsed_over(
        input logic [StampW-1:0] now,
        input logic [StampW-1:0] stamp,
        input logic [LimitW-1:0] limit
    );
        logic [StampW-1:0] diff;
        diff = now - stamp;
        return diff > {{(StampW-LimitW){1'b0}}, limit};
    endfunction

endpackage

FILE: rtl/key_click_event_detector_unit.sv
// ----------------------------------------------------------------------------
// Key click event detector
// Debounces one key and reports click, double click and long press events.
// ----------------------------------------------------------------------------
// Each input beat is one key scan: a wrapping millisecond timestamp and the
// raw key level. Every scan yields exactly one output beat carrying an event
// code (none, single click, double click, long press). The detector updates
// its phase, press/release stamps and click count in the same cycle a scan
// is accepted, so one scan can be taken every clock while ready is high;
// the event lands in an output register. A second output slot catches one
// more event while the downstream side stalls, and input ready drops only when
// both slots are full. Elapsed times are 32-bit wrapping differences that
// must be strictly greater than the programmed limit. The three limits are
// written through a plain write port (index 0 debounce, 1 long press,
// 2 double-click gap, others ignored) and should change only while idle.
// ----------------------------------------------------------------------------
`include "key_click_event_detector_unit_defines.svh"

module key_click_event_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // scan input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kcd_pkg::StampW-1:0]      i_now_ms,
    input  logic                            i_key_down,
    // event output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_event_code,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [kcd_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [kcd_pkg::LimitW-1:0]      i_cfg_data
);
    import kcd_pkg::*;

    t_kcd_cfg   r_cfg;
    t_kcd_state r_state;
    t_kcd_state n_state;
    t_event     n_event;

    logic   r_out_valid;
    t_event r_out_event;
    logic   r_skid_valid;
    t_event r_skid_event;

    logic in_fire;
    logic out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.double_gap_ms <= DOUBLE_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                REG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                REG_DOUBLE_GAP: r_cfg.double_gap_ms <= i_cfg_data;
                default: ; // drop writes past the last register
            endcase
        end
    end

    // Scan step: next state and event for the current beat
    kcd_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_now_ms   (i_now_ms),
        .i_key_down (i_key_down),
        .o_state    (n_state),
        .o_event    (n_event)
    );

    // Ready as long as the spare slot is empty
    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Detector state: advance only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.press_stamp   <= '0;
            r_state.release_stamp <= '0;
            r_state.clicks        <= 2'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output slot plus spare slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                // refill from the spare slot; no beat is taken this cycle
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            // output is stalled: park the new event
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_event <= r_skid_valid ? r_skid_event : n_event;
        end
        if (!out_free && in_fire) begin
            r_skid_event <= n_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_out_event;

    // Checks
    `KCD_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "spare slot full while output slot empty")
    `KCD_ASSERT_NOW(a_clicks_low, i_clk, i_rst_n, 1'b1, r_state.clicks[1] == 1'b0,
        "click count left at two or more")
    `KCD_ASSERT_NOW(a_phase_legal, i_clk, i_rst_n, 1'b1, r_state.phase <= PH_WAIT_DBL,
        "phase holds an unused code")
    `KCD_ASSERT_NEXT(a_double_to_idle, i_clk, i_rst_n, in_fire && (n_event == EV_DOUBLE),
        r_state.phase == PH_IDLE, "double click did not return to idle")

endmodule

FILE: rtl/kcd_step.sv
// ----------------------------------------------------------------------------
// Key click event detector - scan step
// Next phase, stamps, click count and event for one key scan.
// ----------------------------------------------------------------------------
module kcd_step (
    input  kcd_pkg::t_kcd_state            i_state,
    input  kcd_pkg::t_kcd_cfg              i_cfg,
    input  logic [kcd_pkg::StampW-1:0]     i_now_ms,
    input  logic                           i_key_down,
    output kcd_pkg::t_kcd_state            o_state,
    output kcd_pkg::t_event                o_event
);
    import kcd_pkg::*;

    t_kcd_state n_state;
    t_event     n_event;
    logic       dbn_press;
    logic       dbn_release;
    logic       long_hit;
    logic       gap_hit;

    assign dbn_press   = elapsed_over(i_now_ms, i_state.press_stamp, i_cfg.debounce_ms);
    assign dbn_release = elapsed_over(i_now_ms, i_state.release_stamp, i_cfg.debounce_ms);
    assign long_hit    = elapsed_over(i_now_ms, i_state.press_stamp, i_cfg.long_press_ms);
    assign gap_hit     = elapsed_over(i_now_ms, i_state.release_stamp, i_cfg.double_gap_ms);

    always_comb begin
        n_state = i_state;
        n_event = EV_NONE;
        unique case (i_state.phase)
            PH_DEBOUNCE: begin
                if (dbn_press) begin
                    if (i_key_down) begin
                        n_state.phase  = PH_PRESSED;
                        n_state.clicks = i_state.clicks + 2'd1;
                    end else begin
                        n_state.phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!i_key_down) begin
                    n_state.phase         = PH_RELEASE;
                    n_state.release_stamp = i_now_ms;
                end else if (long_hit) begin
                    n_state.phase = PH_LONG;
                    n_event       = EV_LONG;
                end
            end
            PH_LONG: begin
                if (!i_key_down) begin
                    n_state.phase  = PH_IDLE;
                    n_state.clicks = 2'd0;
                end
            end
            PH_RELEASE: begin
                if (dbn_release) begin
                    if (i_state.clicks == 2'd1) begin
                        n_state.phase = PH_WAIT_DBL;
                    end else begin
                        n_state.phase  = PH_IDLE;
                        n_state.clicks = 2'd0;
                    end
                end
            end
            PH_WAIT_DBL: begin
                if (gap_hit) begin
                    n_state.phase = PH_IDLE;
                    if (i_state.clicks == 2'd1) begin
                        n_state.clicks = 2'd0;
                        n_event        = EV_CLICK;
                    end
                end else if (i_key_down) begin
                    n_state.phase       = PH_DEBOUNCE;
                    n_state.press_stamp = i_now_ms;
                end
            end
            default: begin
                // idle, and any stray code treated as idle
                if (i_key_down) begin
                    n_state.phase       = PH_DEBOUNCE;
                    n_state.press_stamp = i_now_ms;
                end
            end
        endcase

        // second confirmed press wins over anything set above
        if (n_state.clicks == 2'd2) begin
            n_state.clicks = 2'd0;
            n_state.phase  = PH_IDLE;
            n_event        = EV_DOUBLE;
        end
    end

    assign o_state = n_state;
    assign o_event = n_event;

endmodule

FILE: bench/key_click_event_checker.sv
// ----------------------------------------------------------------------------
// Key click event checker
// Watches the scan, event and limit ports of the detector, predicts the event
// of every accepted scan and compares it with the event beats that come out.
// ----------------------------------------------------------------------------
module key_click_event_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [kcd_pkg::StampW-1:0]    i_now_ms,
    input  logic                          i_key_down,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_event_code,
    input  logic                          i_cfg_we,
    input  logic [kcd_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [kcd_pkg::LimitW-1:0]    i_cfg_data,
    output int                            o_pending,
    output int                            o_mismatches
);
    import kcd_pkg::*;

    typedef struct {
        t_event      code;
        int unsigned scan;
    } t_due_event;

    // Shadow of the detector state and limits.
    t_phase            ph;
    logic [StampW-1:0] press_at;
    logic [StampW-1:0] release_at;
    logic [1:0]        click_cnt;
    t_kcd_cfg          lim;

    t_due_event  events_due[$];
    t_due_event  want;
    int          mismatch_count = 0;
    int unsigned scan_no = 0;
    int unsigned beat_no = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic bit span_exceeds(
        input logic [StampW-1:0] now,
        input logic [StampW-1:0] stamp,
        input logic [LimitW-1:0] limit
    );
        logic [StampW-1:0] span;
        span = now - stamp;
        return span > StampW'(limit);
    endfunction

    // Advance the shadow state by one scan and return the event it reports.
    function automatic t_event next_click_event(
        input logic [StampW-1:0] now,
        input logic              down
    );
        t_event ev;
        ev = EV_NONE;
        case (ph)
            PH_DEBOUNCE: begin
                if (span_exceeds(now, press_at, lim.debounce_ms)) begin
                    if (down) begin
                        ph = PH_PRESSED;
                        click_cnt = click_cnt + 2'd1;
                    end else begin
                        ph = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!down) begin
                    ph = PH_RELEASE;
                    release_at = now;
                end else if (span_exceeds(now, press_at, lim.long_press_ms)) begin
                    ph = PH_LONG;
                    ev = EV_LONG;
                end
            end
            PH_LONG: begin
                if (!down) begin
                    ph = PH_IDLE;
                    click_cnt = 2'd0;
                end
            end
            PH_RELEASE: begin
                if (span_exceeds(now, release_at, lim.debounce_ms)) begin
                    if (click_cnt == 2'd1) begin
                        ph = PH_WAIT_DBL;
                    end else begin
                        ph = PH_IDLE;
                        click_cnt = 2'd0;
                    end
                end
            end
            PH_WAIT_DBL: begin
                if (span_exceeds(now, release_at, lim.double_gap_ms)) begin
                    ph = PH_IDLE;
                    if (click_cnt == 2'd1) begin
                        click_cnt = 2'd0;
                        ev = EV_CLICK;
                    end
                end else if (down) begin
                    ph = PH_DEBOUNCE;
                    press_at = now;
                end
            end
            default: begin
                if (down) begin
                    ph = PH_DEBOUNCE;
                    press_at = now;
                end
            end
        endcase
        // A second confirmed press wins over anything set above.
        if (click_cnt == 2'd2) begin
            click_cnt = 2'd0;
            ph = PH_IDLE;
            ev = EV_DOUBLE;
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph = PH_IDLE;
            press_at = '0;
            release_at = '0;
            click_cnt = 2'd0;
            lim.debounce_ms = DEBOUNCE_RST;
            lim.long_press_ms = LONG_PRESS_RST;
            lim.double_gap_ms = DOUBLE_GAP_RST;
            events_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEBOUNCE:   lim.debounce_ms = i_cfg_data;
                    REG_LONG_PRESS: lim.long_press_ms = i_cfg_data;
                    REG_DOUBLE_GAP: lim.double_gap_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // An event beat always belongs to an earlier scan: pop before push.
            if (i_out_valid && i_out_ready) begin
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("event beat %0d (code %0d) with no scan pending",
                                              beat_no, i_event_code));
                end else begin
                    want = events_due.pop_front();
                    if (i_event_code !== want.code) begin
                        report_mismatch($sformatf("scan %0d: event_code %0d, expected %0d (%s)",
                                                  want.scan, i_event_code, want.code,
                                                  want.code.name()));
                    end
                end
                beat_no++;
            end
            if (i_in_valid && i_in_ready) begin
                want.code = next_click_event(i_now_ms, i_key_down);
                want.scan = scan_no;
                events_due.push_back(want);
                scan_no++;
            end
        end
        o_pending <= events_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: bench/key_click_event_detector_unit_test.sv
// ----------------------------------------------------------------------------
// Key click event detector testbench
// Drives timed key scans and limit writes into the detector, with random
// gaps on both channels; a checker beside the block predicts every event.
// ----------------------------------------------------------------------------
module key_click_event_detector_unit_test;
    import kcd_pkg::*;

    localparam int unsigned RunLimit    = 100000;
    localparam int unsigned RandomScans = 850;
    localparam int unsigned PhaseCount  = 10;
    localparam int unsigned TailCycles  = 8;
    // Index past the last limit register; writes to it must change nothing.
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [StampW-1:0]  now_ms = '0;
    logic               key_down = 1'b0;
    logic               out_ready = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [LimitW-1:0]  cfg_data = '0;

    logic               in_ready;
    logic               out_valid;
    logic [1:0]         event_code;
    int                 pending;
    int                 mismatches;

    // Gap-free stretches for each side.
    bit                 tx_calm = 1'b0;
    bit                 rx_calm = 1'b0;

    // Key time of the latest scan and the limits now programmed.
    logic [StampW-1:0]  clock_ms = '0;
    int unsigned        db_ms = 32'(DEBOUNCE_RST);
    int unsigned        lp_ms = 32'(LONG_PRESS_RST);
    int unsigned        gp_ms = 32'(DOUBLE_GAP_RST);
    int unsigned        scans_sent = 0;

    key_click_event_detector_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_now_ms     (now_ms),
        .i_key_down   (key_down),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_event_code (event_code),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    key_click_event_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_now_ms     (now_ms),
        .i_key_down   (key_down),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_event_code (event_code),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Offer one scan beat after a random gap and hold it until taken.
    // Valid stays high after the beat so back-to-back beats never glitch it.
    task automatic send_scan(input logic [StampW-1:0] t, input logic d);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= t;
        key_down <= d;
        do @(posedge clk); while (!in_ready);
        scans_sent++;
    endtask

    task automatic scan_at(input logic [StampW-1:0] t, input logic d);
        clock_ms = t;
        send_scan(t, d);
    endtask

    task automatic scan_after(input int unsigned delta, input logic d);
        scan_at(clock_ms + delta, d);
    endtask

    // Pick a time step around a limit: on it, just past it, up to it or tiny.
    function automatic int unsigned step_near(input int unsigned lim);
        case ($urandom_range(0, 4))
            0: return lim;
            1: return lim + 1;
            2: return $urandom_range(0, lim);
            3: return lim + 1 + $urandom_range(0, 3);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic hold_key(input logic d, input int unsigned n, input int unsigned lim);
        repeat (n) scan_after(step_near(lim), d);
    endtask

    // Press, hold (sometimes long), release, then rest for the given time.
    task automatic tap(input int unsigned rest);
        scan_after($urandom_range(0, 3), 1'b1);
        hold_key(1'b1, $urandom_range(1, 3), db_ms);
        if ($urandom_range(0, 4) == 0) begin
            hold_key(1'b1, 2, lp_ms);
        end
        hold_key(1'b0, $urandom_range(1, 3), db_ms);
        scan_after(rest, 1'b0);
    endtask

    task automatic play_gesture();
        case ($urandom_range(0, 9))
            0, 1, 2: tap(step_near(gp_ms));
            3, 4, 5: begin
                // second tap inside the double window
                tap($urandom_range(0, gp_ms));
                tap(step_near(gp_ms));
            end
            6: begin
                // second press that bounces open at the end of its debounce
                tap($urandom_range(0, gp_ms));
                scan_after($urandom_range(0, gp_ms), 1'b1);
                scan_after(step_near(db_ms), 1'b0);
                tap(step_near(gp_ms));
            end
            7, 8: begin
                repeat ($urandom_range(4, 8)) begin
                    case ($urandom_range(0, 2))
                        0: scan_after(step_near(db_ms), 1'($urandom_range(0, 1)));
                        1: scan_after(step_near(lp_ms), 1'($urandom_range(0, 1)));
                        default: scan_after(step_near(gp_ms), 1'($urandom_range(0, 1)));
                    endcase
                end
            end
            default: begin
                // jump anywhere on the 32-bit clock
                repeat ($urandom_range(1, 3)) scan_at($urandom, 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // Drop valid and hold until every predicted event beat has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Program all three limits, then poke the unused index with junk.
    task automatic write_limits(
        input logic [LimitW-1:0] d,
        input logic [LimitW-1:0] l,
        input logic [LimitW-1:0] g
    );
        logic [LimitW-1:0] junk;
        junk = LimitW'($urandom);
        cfg_we <= 1'b1;
        cfg_idx <= REG_DEBOUNCE;
        cfg_data <= d;
        @(posedge clk);
        cfg_idx <= REG_LONG_PRESS;
        cfg_data <= l;
        @(posedge clk);
        cfg_idx <= REG_DOUBLE_GAP;
        cfg_data <= g;
        @(posedge clk);
        cfg_idx <= REG_UNUSED;
        cfg_data <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        db_ms = 32'(d);
        lp_ms = 32'(l);
        gp_ms = 32'(g);
    endtask

    // Event side: stall a random number of cycles before taking each beat.
    initial begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RunLimit) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans on the reset limits (debounce 20, long 3000, gap 500).
        // Single click; the window expires while the key is down again, and
        // expiry is checked before the new press.
        scan_at(32'd0, 1'b0);
        scan_at(32'd100, 1'b1);
        scan_at(32'd120, 1'b1);       // exactly on the limit: not yet elapsed
        scan_at(32'd121, 1'b1);
        scan_at(32'd200, 1'b0);
        scan_at(32'd221, 1'b0);
        scan_at(32'd722, 1'b1);
        // Double click.
        scan_at(32'd1000, 1'b1);
        scan_at(32'd1021, 1'b1);
        scan_at(32'd1050, 1'b0);
        scan_at(32'd1071, 1'b0);
        scan_at(32'd1100, 1'b1);
        scan_at(32'd1121, 1'b1);
        // Top of the clock, then a long press held across the wrap.
        scan_at(32'hFFFF_FFFF, 1'b0);
        scan_at(32'hFFFF_FF00, 1'b1);
        scan_at(32'hFFFF_FF15, 1'b1);
        scan_at(32'h0000_0AB9, 1'b1);
        scan_at(32'h0000_0AC0, 1'b0);
        // Second press bounces open: back to idle with one click kept, so the
        // next confirmed press is a double click right away.
        scan_at(32'd6000, 1'b1);
        scan_at(32'd6021, 1'b1);
        scan_at(32'd6040, 1'b0);
        scan_at(32'd6061, 1'b0);
        scan_at(32'd6100, 1'b1);
        scan_at(32'd6121, 1'b0);
        scan_at(32'd6200, 1'b1);
        scan_at(32'd6221, 1'b1);

        // Random gestures in phases, each on its own set of limits.
        for (int unsigned p = 0; p < PhaseCount; p++) begin
            wait_drained();
            tx_calm = (p == 4);
            rx_calm = (p == 4) || (p == 8);
            case (p)
                0: write_limits(16'd0, 16'd0, 16'd0);
                1: write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_limits(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_GAP_RST);
                5: write_limits(LimitW'($urandom), LimitW'($urandom), LimitW'($urandom));
                default: write_limits(LimitW'($urandom_range(0, 8)),
                                      LimitW'($urandom_range(4, 80)),
                                      LimitW'($urandom_range(2, 40)));
            endcase
            if (p == 7) begin
                // run this phase across the clock wrap
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            end
            phase_end = scans_sent + RandomScans / PhaseCount;
            while (scans_sent < phase_end) begin
                play_gesture();
                // now and then hold the sender until the block has emptied
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
